### hw/rtl/hic_pkg.sv
// ----------------------------------------------------------------------------
// hic_pkg
// Shared types, constants and the micro-sequence for the homography inlier
// check.
// ----------------------------------------------------------------------------
`default_nettype none

package hic_pkg;

  // Sizes and scaling.
  localparam int MAX_POINTS = 4096;
  localparam int TOL_Q4     = 48;
  localparam int TALLY_CAP  = (MAX_POINTS < 8191) ? MAX_POINTS : 8191;
  localparam int COEF_W     = 48;
  localparam int PT_W       = 16;
  localparam int TALLY_W    = 13;
  localparam int IDX_W      = 8;
  localparam int NUM_COEF   = 8;
  localparam int LIMB_W     = 32;
  localparam int MAG_W      = 96;
  localparam int ACC_W      = 192;
  localparam int PC_W       = 7;
  localparam logic [PC_W-1:0] UC_LAST = 7'd72;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_H00 = 8'd0, REG_H01 = 8'd1, REG_H02 = 8'd2, REG_H10 = 8'd3,
    REG_H11 = 8'd4, REG_H12 = 8'd5, REG_H20 = 8'd6, REG_H21 = 8'd7
  } reg_idx_t;

  // Operand sources of the shared multiplier.
  typedef enum logic [4:0] {
    SRC_ZERO, SRC_H00, SRC_H01, SRC_H02, SRC_H10, SRC_H11, SRC_H12,
    SRC_H20, SRC_H21, SRC_SX, SRC_SY, SRC_DX, SRC_DY, SRC_K16, SRC_KTOL,
    SRC_U, SRC_V, SRC_W, SRC_EX, SRC_EY, SRC_TW
  } src_t;

  localparam int SRC_COUNT = 21;

  // Accumulator operations.
  typedef enum logic [2:0] {
    OP_NOP, OP_CLR, OP_CLR_ONE, OP_MAC, OP_STORE, OP_FIN
  } op_t;

  // One datapath command. For a store, field a names the destination.
  typedef struct packed {
    op_t        op;
    src_t       a;
    logic [1:0] al;
    src_t       b;
    logic [1:0] bl;
    logic       neg;
  } cmd_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;
    cmd_t cmd;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic fin;
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_RUN, ST_DRAIN, ST_OUT
  } state_t;

  function automatic cmd_t mk(op_t op, src_t a, logic [1:0] al, src_t b,
                              logic [1:0] bl, logic neg);
    cmd_t c;
    c.op  = op;
    c.a   = a;
    c.al  = al;
    c.b   = b;
    c.bl  = bl;
    c.neg = neg;
    return c;
  endfunction

  // Limb pair of a three by three limb product, in row order.
  function automatic logic [3:0] pair(logic [3:0] k);
    logic [3:0] r;
    case (k)
      4'd0:    r = {2'd0, 2'd0};
      4'd1:    r = {2'd0, 2'd1};
      4'd2:    r = {2'd0, 2'd2};
      4'd3:    r = {2'd1, 2'd0};
      4'd4:    r = {2'd1, 2'd1};
      4'd5:    r = {2'd1, 2'd2};
      4'd6:    r = {2'd2, 2'd0};
      4'd7:    r = {2'd2, 2'd1};
      default: r = {2'd2, 2'd2};
    endcase
    return r;
  endfunction

  // Micro-sequence for one correspondence.
  function automatic cmd_t ucode(logic [PC_W-1:0] pc);
    cmd_t       c;
    logic [3:0] p;
    p = 4'd0;
    c = mk(OP_NOP, SRC_ZERO, 2'd0, SRC_ZERO, 2'd0, 1'b0);
    case (pc)
      // u = h00*sx + h01*sy + h02*16
      7'd0:  c = mk(OP_CLR, SRC_ZERO, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      7'd1:  c = mk(OP_MAC, SRC_H00, 2'd0, SRC_SX, 2'd0, 1'b0);
      7'd2:  c = mk(OP_MAC, SRC_H00, 2'd1, SRC_SX, 2'd0, 1'b0);
      7'd3:  c = mk(OP_MAC, SRC_H01, 2'd0, SRC_SY, 2'd0, 1'b0);
      7'd4:  c = mk(OP_MAC, SRC_H01, 2'd1, SRC_SY, 2'd0, 1'b0);
      7'd5:  c = mk(OP_MAC, SRC_H02, 2'd0, SRC_K16, 2'd0, 1'b0);
      7'd6:  c = mk(OP_MAC, SRC_H02, 2'd1, SRC_K16, 2'd0, 1'b0);
      7'd7:  c = mk(OP_STORE, SRC_U, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      // v = h10*sx + h11*sy + h12*16
      7'd8:  c = mk(OP_CLR, SRC_ZERO, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      7'd9:  c = mk(OP_MAC, SRC_H10, 2'd0, SRC_SX, 2'd0, 1'b0);
      7'd10: c = mk(OP_MAC, SRC_H10, 2'd1, SRC_SX, 2'd0, 1'b0);
      7'd11: c = mk(OP_MAC, SRC_H11, 2'd0, SRC_SY, 2'd0, 1'b0);
      7'd12: c = mk(OP_MAC, SRC_H11, 2'd1, SRC_SY, 2'd0, 1'b0);
      7'd13: c = mk(OP_MAC, SRC_H12, 2'd0, SRC_K16, 2'd0, 1'b0);
      7'd14: c = mk(OP_MAC, SRC_H12, 2'd1, SRC_K16, 2'd0, 1'b0);
      7'd15: c = mk(OP_STORE, SRC_V, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      // w = h20*sx + h21*sy + 1
      7'd16: c = mk(OP_CLR_ONE, SRC_ZERO, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      7'd17: c = mk(OP_MAC, SRC_H20, 2'd0, SRC_SX, 2'd0, 1'b0);
      7'd18: c = mk(OP_MAC, SRC_H20, 2'd1, SRC_SX, 2'd0, 1'b0);
      7'd19: c = mk(OP_MAC, SRC_H21, 2'd0, SRC_SY, 2'd0, 1'b0);
      7'd20: c = mk(OP_MAC, SRC_H21, 2'd1, SRC_SY, 2'd0, 1'b0);
      7'd21: c = mk(OP_STORE, SRC_W, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      // ex = 16u - dx*w
      7'd22: c = mk(OP_CLR, SRC_ZERO, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      7'd23: c = mk(OP_MAC, SRC_U, 2'd0, SRC_K16, 2'd0, 1'b0);
      7'd24: c = mk(OP_MAC, SRC_U, 2'd1, SRC_K16, 2'd0, 1'b0);
      7'd25: c = mk(OP_MAC, SRC_U, 2'd2, SRC_K16, 2'd0, 1'b0);
      7'd26: c = mk(OP_MAC, SRC_DX, 2'd0, SRC_W, 2'd0, 1'b1);
      7'd27: c = mk(OP_MAC, SRC_DX, 2'd0, SRC_W, 2'd1, 1'b1);
      7'd28: c = mk(OP_MAC, SRC_DX, 2'd0, SRC_W, 2'd2, 1'b1);
      7'd29: c = mk(OP_STORE, SRC_EX, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      // ey = 16v - dy*w
      7'd30: c = mk(OP_CLR, SRC_ZERO, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      7'd31: c = mk(OP_MAC, SRC_V, 2'd0, SRC_K16, 2'd0, 1'b0);
      7'd32: c = mk(OP_MAC, SRC_V, 2'd1, SRC_K16, 2'd0, 1'b0);
      7'd33: c = mk(OP_MAC, SRC_V, 2'd2, SRC_K16, 2'd0, 1'b0);
      7'd34: c = mk(OP_MAC, SRC_DY, 2'd0, SRC_W, 2'd0, 1'b1);
      7'd35: c = mk(OP_MAC, SRC_DY, 2'd0, SRC_W, 2'd1, 1'b1);
      7'd36: c = mk(OP_MAC, SRC_DY, 2'd0, SRC_W, 2'd2, 1'b1);
      7'd37: c = mk(OP_STORE, SRC_EY, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      // tw = tol*w
      7'd38: c = mk(OP_CLR, SRC_ZERO, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      7'd39: c = mk(OP_MAC, SRC_W, 2'd0, SRC_KTOL, 2'd0, 1'b0);
      7'd40: c = mk(OP_MAC, SRC_W, 2'd1, SRC_KTOL, 2'd0, 1'b0);
      7'd41: c = mk(OP_MAC, SRC_W, 2'd2, SRC_KTOL, 2'd0, 1'b0);
      7'd42: c = mk(OP_STORE, SRC_TW, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      // Gap so that tw is written back before it is read.
      7'd43: c = mk(OP_NOP, SRC_ZERO, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      7'd44: c = mk(OP_CLR, SRC_ZERO, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      7'd72: c = mk(OP_FIN, SRC_ZERO, 2'd0, SRC_ZERO, 2'd0, 1'b0);
      default: begin
        // tw^2 - ex^2 - ey^2, one limb product a step.
        if (pc >= 7'd45 && pc <= 7'd53) begin
          p = pair(4'(pc - 7'd45));
          c = mk(OP_MAC, SRC_TW, p[3:2], SRC_TW, p[1:0], 1'b0);
        end else if (pc >= 7'd54 && pc <= 7'd62) begin
          p = pair(4'(pc - 7'd54));
          c = mk(OP_MAC, SRC_EX, p[3:2], SRC_EX, p[1:0], 1'b1);
        end else if (pc >= 7'd63 && pc <= 7'd71) begin
          p = pair(4'(pc - 7'd63));
          c = mk(OP_MAC, SRC_EY, p[3:2], SRC_EY, p[1:0], 1'b1);
        end
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/homography_inlier_check.sv
// ----------------------------------------------------------------------------
// homography_inlier_check
// RANSAC consensus test: maps a source point through a homography and checks
// the transfer distance to its match without division.
// ----------------------------------------------------------------------------
// A result word is formed by 73 micro-steps through one shared 32x32 multiplier
// feeding a 192-bit accumulator, past the operand limb-select, multiply and
// accumulate stages. One word is in work at a time; the next word is taken
// only in the idle state that follows the taking of the result, so a result
// that waits for out_ready also holds back the next word.
// The configuration port is always ready; write it only while no word is in
// work.
`default_nettype none

module homography_inlier_check (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [hic_pkg::PT_W-1:0]     src_x,
  input  wire logic [hic_pkg::PT_W-1:0]     src_y,
  input  wire logic [hic_pkg::PT_W-1:0]     dst_x,
  input  wire logic [hic_pkg::PT_W-1:0]     dst_y,
  input  wire logic                         final_pair,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              is_inlier,
  output logic                              degenerate,
  output logic [hic_pkg::TALLY_W-1:0]       inlier_total,
  output logic                              set_done,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [hic_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [hic_pkg::COEF_W-1:0]   cfg_data
);

  hic_pkg::ctl_t  ctl;
  hic_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  hic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  hic_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .src_x        (src_x),
    .src_y        (src_y),
    .dst_x        (dst_x),
    .dst_y        (dst_y),
    .final_pair   (final_pair),
    .is_inlier    (is_inlier),
    .degenerate   (degenerate),
    .inlier_total (inlier_total),
    .set_done     (set_done)
  );

endmodule

`default_nettype wire

### hw/rtl/hic_datapath.sv
// ----------------------------------------------------------------------------
// hic_datapath
// Configuration registers, operand store and the shared 32x32 multiplier
// with a signed wide accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module hic_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire hic_pkg::ctl_t                       ctl,
  output hic_pkg::stat_t                           stat,
  input  wire logic                                cfg_we,
  input  wire logic [hic_pkg::IDX_W-1:0]           cfg_index,
  input  wire logic [hic_pkg::COEF_W-1:0]          cfg_data,
  input  wire logic [hic_pkg::PT_W-1:0]            src_x,
  input  wire logic [hic_pkg::PT_W-1:0]            src_y,
  input  wire logic [hic_pkg::PT_W-1:0]            dst_x,
  input  wire logic [hic_pkg::PT_W-1:0]            dst_y,
  input  wire logic                                final_pair,
  output logic                                     is_inlier,
  output logic                                     degenerate,
  output logic [hic_pkg::TALLY_W-1:0]              inlier_total,
  output logic                                     set_done
);

  localparam int MW = hic_pkg::MAG_W;
  localparam int LW = hic_pkg::LIMB_W;
  localparam int AW = hic_pkg::ACC_W;

  localparam logic [hic_pkg::IDX_W-1:0] IDX_LIMIT = hic_pkg::IDX_W'(hic_pkg::NUM_COEF);

  logic [hic_pkg::COEF_W-1:0] coef [hic_pkg::NUM_COEF];
  logic [hic_pkg::PT_W-1:0]   sx, sy, dx, dy;
  logic                       last;

  // Sign-magnitude intermediates.
  logic [MW-1:0] u_mag, v_mag, w_mag, ex_mag, ey_mag, tw_mag;
  logic          u_neg, v_neg, w_neg, ex_neg, ey_neg, tw_neg;
  logic          w_zero;

  logic [MW-1:0] smag [hic_pkg::SRC_COUNT];
  logic          sneg [hic_pkg::SRC_COUNT];

  // Pipeline registers.
  hic_pkg::op_t  s1_op, s2_op;
  hic_pkg::src_t s1_dst, s2_dst;
  logic [LW-1:0] s1_a, s1_b;
  logic          s1_neg, s2_neg;
  logic [2:0]    s1_sh, s2_sh;
  logic [2*LW-1:0] s2_prod;

  logic [AW-1:0] acc;
  logic [AW-1:0] acc_abs;
  logic [AW-1:0] addend;
  logic [hic_pkg::TALLY_W-1:0] tally, tally_next;
  logic          inl;

  function automatic logic [MW-1:0] coef_abs(logic [hic_pkg::COEF_W-1:0] h);
    logic [hic_pkg::COEF_W-1:0] m;
    m = h[hic_pkg::COEF_W-1] ? (~h + 1'b1) : h;
    return MW'(m);
  endfunction

  function automatic logic [LW-1:0] limb(logic [MW-1:0] m, logic [1:0] i);
    logic [LW-1:0] r;
    case (i)
      2'd0:    r = m[LW-1:0];
      2'd1:    r = m[2*LW-1:LW];
      2'd2:    r = m[3*LW-1:2*LW];
      default: r = '0;
    endcase
    return r;
  endfunction

  // Operand magnitudes and signs by source.
  always_comb begin
    for (int k = 0; k < hic_pkg::SRC_COUNT; k++) begin
      smag[k] = '0;
      sneg[k] = 1'b0;
    end
    for (int k = 0; k < hic_pkg::NUM_COEF; k++) begin
      smag[int'(hic_pkg::SRC_H00) + k] = coef_abs(coef[k]);
      sneg[int'(hic_pkg::SRC_H00) + k] = coef[k][hic_pkg::COEF_W-1];
    end
    smag[hic_pkg::SRC_SX]   = MW'(sx);
    smag[hic_pkg::SRC_SY]   = MW'(sy);
    smag[hic_pkg::SRC_DX]   = MW'(dx);
    smag[hic_pkg::SRC_DY]   = MW'(dy);
    smag[hic_pkg::SRC_K16]  = MW'(16);
    smag[hic_pkg::SRC_KTOL] = MW'(hic_pkg::TOL_Q4);
    smag[hic_pkg::SRC_U]    = u_mag;
    sneg[hic_pkg::SRC_U]    = u_neg;
    smag[hic_pkg::SRC_V]    = v_mag;
    sneg[hic_pkg::SRC_V]    = v_neg;
    smag[hic_pkg::SRC_W]    = w_mag;
    sneg[hic_pkg::SRC_W]    = w_neg;
    smag[hic_pkg::SRC_EX]   = ex_mag;
    sneg[hic_pkg::SRC_EX]   = ex_neg;
    smag[hic_pkg::SRC_EY]   = ey_mag;
    sneg[hic_pkg::SRC_EY]   = ey_neg;
    smag[hic_pkg::SRC_TW]   = tw_mag;
    sneg[hic_pkg::SRC_TW]   = tw_neg;
  end

  // Configuration registers; reset to the identity mapping.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < hic_pkg::NUM_COEF; k++) begin
        coef[k] <= (k == int'(hic_pkg::REG_H00) || k == int'(hic_pkg::REG_H11)) ?
                   48'd4294967296 : '0;
      end
    end else if (cfg_we && cfg_index < IDX_LIMIT) begin
      coef[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      sx   <= src_x;
      sy   <= src_y;
      dx   <= dst_x;
      dy   <= dst_y;
      last <= final_pair;
    end
  end

  // Stage 1: operand limb select.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_op <= hic_pkg::OP_NOP;
    end else begin
      s1_op <= ctl.cmd.op;
    end
    s1_dst <= ctl.cmd.a;
    s1_a   <= limb(smag[ctl.cmd.a], ctl.cmd.al);
    s1_b   <= limb(smag[ctl.cmd.b], ctl.cmd.bl);
    s1_neg <= sneg[ctl.cmd.a] ^ sneg[ctl.cmd.b] ^ ctl.cmd.neg;
    s1_sh  <= 3'(ctl.cmd.al) + 3'(ctl.cmd.bl);
  end

  // Stage 2: multiply.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_op <= hic_pkg::OP_NOP;
    end else begin
      s2_op <= s1_op;
    end
    s2_dst  <= s1_dst;
    s2_prod <= s1_a * s1_b;
    s2_neg  <= s1_neg;
    s2_sh   <= s1_sh;
  end

  // Shifted product and accumulator magnitude.
  always_comb begin
    addend  = AW'(s2_prod) << (LW * int'(s2_sh));
    acc_abs = acc[AW-1] ? (~acc + 1'b1) : acc;
  end

  assign inl = !w_zero && !acc[AW-1];

  always_comb begin
    tally_next = tally;
    if (inl && tally < hic_pkg::TALLY_W'(hic_pkg::TALLY_CAP)) begin
      tally_next = tally + 1'b1;
    end
  end

  // Stage 3: accumulate, write back, finish.
  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
    end else if (s2_op == hic_pkg::OP_FIN) begin
      tally <= last ? '0 : tally_next;
    end
    case (s2_op)
      hic_pkg::OP_CLR:     acc <= '0;
      hic_pkg::OP_CLR_ONE: acc <= AW'(1) << 36;
      hic_pkg::OP_MAC:     acc <= s2_neg ? (acc - addend) : (acc + addend);
      hic_pkg::OP_STORE: begin
        case (s2_dst)
          hic_pkg::SRC_U: begin
            u_mag <= acc_abs[MW-1:0];
            u_neg <= acc[AW-1];
          end
          hic_pkg::SRC_V: begin
            v_mag <= acc_abs[MW-1:0];
            v_neg <= acc[AW-1];
          end
          hic_pkg::SRC_W: begin
            w_mag  <= acc_abs[MW-1:0];
            w_neg  <= acc[AW-1];
            w_zero <= (acc == '0);
          end
          hic_pkg::SRC_EX: begin
            ex_mag <= acc_abs[MW-1:0];
            ex_neg <= acc[AW-1];
          end
          hic_pkg::SRC_EY: begin
            ey_mag <= acc_abs[MW-1:0];
            ey_neg <= acc[AW-1];
          end
          hic_pkg::SRC_TW: begin
            tw_mag <= acc_abs[MW-1:0];
            tw_neg <= acc[AW-1];
          end
          default: ;
        endcase
      end
      hic_pkg::OP_FIN: begin
        is_inlier    <= inl;
        degenerate   <= w_zero;
        inlier_total <= tally_next;
        set_done     <= last;
      end
      default: ;
    endcase
  end

  assign stat.fin = (s2_op == hic_pkg::OP_FIN);

endmodule

`default_nettype wire

### hw/rtl/hic_ctrl.sv
// ----------------------------------------------------------------------------
// hic_ctrl
// Sequencer: takes a word, steps the micro-sequence through the datapath
// and holds the result word until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hic_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output hic_pkg::ctl_t       ctl,
  input  wire hic_pkg::stat_t stat
);

  hic_pkg::state_t        state, state_next;
  logic [hic_pkg::PC_W-1:0] pc, pc_next;

  // State and sequence counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hic_pkg::ST_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    pc_next     = pc;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ctl.load_in = 1'b0;
    ctl.cmd     = hic_pkg::mk(hic_pkg::OP_NOP, hic_pkg::SRC_ZERO, 2'd0,
                              hic_pkg::SRC_ZERO, 2'd0, 1'b0);
    case (state)
      hic_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        pc_next  = '0;
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next  = hic_pkg::ST_RUN;
        end
      end
      hic_pkg::ST_RUN: begin
        ctl.cmd = hic_pkg::ucode(pc);
        pc_next = pc + 1'b1;
        if (pc == hic_pkg::UC_LAST) begin
          state_next = hic_pkg::ST_DRAIN;
        end
      end
      hic_pkg::ST_DRAIN: begin
        if (stat.fin) begin
          state_next = hic_pkg::ST_OUT;
        end
      end
      hic_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = hic_pkg::ST_IDLE;
        end
      end
      default: state_next = hic_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/hic_checker.sv
// ----------------------------------------------------------------------------
// hic_checker
// Port-level checks for the homography inlier check.
// ----------------------------------------------------------------------------
`default_nettype none

module hic_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       is_inlier,
  input wire logic                       degenerate,
  input wire logic [hic_pkg::TALLY_W-1:0] inlier_total
);

  // The block never offers to take a word while a result is pending.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("in_ready while result pending");

  // A result never appears in the cycle right after a word is taken.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  // A degenerate pair is never an inlier.
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_inlier && degenerate)) else $error("degenerate inlier");

  // The running count stays within the cap and counts an inlier.
  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (inlier_total <= hic_pkg::TALLY_W'(hic_pkg::TALLY_CAP)) &&
                  (!is_inlier || inlier_total != '0))
    else $error("inlier_total out of range");

endmodule

bind homography_inlier_check hic_checker u_hic_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .is_inlier    (is_inlier),
  .degenerate   (degenerate),
  .inlier_total (inlier_total)
);

`default_nettype wire
